// File: hdl/rcac_pkg.sv
// Shared types and constants for the range color assign/count block.
`timescale 1ns / 1ps
package rcac_pkg;

   localparam int POS_W   = 11;  // endpoint and board length width
   localparam int COLOR_W = 6;   // paint color field width
   localparam int COUNT_W = 6;   // distinct count field width

   localparam logic CMD_ASSIGN = 1'b0;
   localparam logic CMD_COUNT  = 1'b1;

   localparam logic [POS_W-1:0] BOARD_RESET = 11'd1024;

   typedef struct packed {
      logic               command;
      logic [POS_W-1:0]   left_end;
      logic [POS_W-1:0]   right_end;
      logic [COLOR_W-1:0] paint_color;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] distinct_count;
      logic               bad_range;
   } rsp_type;

   // one checked request handed to the walker
   typedef struct packed {
      logic               bad;
      logic               command;
      logic [POS_W-1:0]   first;
      logic [POS_W-1:0]   last;
      logic [COLOR_W-1:0] color;
   } job_type;

   // walker to tally
   typedef struct packed {
      logic clear;
      logic read;
   } tally_ctl_type;

   // walker status seen by the top level
   typedef struct packed {
      logic idle;
      logic clearing;
      logic done;
   } walk_stat_type;

endpackage

// File: hdl/range_color_assign_count.sv
// Top level of the range color assign/count block.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_data (req_type)
//   rsp      out  rsp_valid/rsp_ready    rsp_data (rsp_type)
//   csr      in   csr_valid/csr_ready    csr_data (board length)
//
// One request at a time. The walk over the color store goes one position per
// cycle; a rejected request skips it. The walker takes the next request once
// its result has gone into the rsp register.
// After reset a clearing pass sets every position to color 1; no request
// is accepted until it ends (csr writes are).
// A finished result waits in the rsp register; the next request may be
// accepted meanwhile, and only its own result waits for the register.
`timescale 1ns / 1ps
module range_color_assign_count
   import rcac_pkg::*;
#(
   parameter int POSITIONS = 1024,
   parameter int COLORS    = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [POS_W-1:0] csr_data
);

   localparam int AW = $clog2(POSITIONS);
   localparam int CW = $clog2(COLORS);
   // board lengths above the store depth act as the depth
   localparam logic [POS_W-1:0] POS_CAP =
      (POSITIONS > 2047) ? {POS_W{1'b1}} : POS_W'(POSITIONS);

   logic [POS_W-1:0] board_ff;
   logic [POS_W-1:0] eff_len;
   logic [POS_W-1:0] lo_end;
   logic [POS_W-1:0] hi_end;
   logic             color_bad;
   logic             start;
   job_type          job;

   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   logic             slot_free;

   tally_ctl_type    tally_ctl;
   logic [COUNT_W-1:0] tally_count;
   logic             ram_we;
   logic             ram_re;
   logic [AW-1:0]    ram_addr;
   logic [CW-1:0]    ram_wdata;
   logic [CW-1:0]    ram_rdata;
   rsp_type          result;
   walk_stat_type    walk_stat;

   // board length register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         board_ff <= BOARD_RESET;
      end else if (csr_valid) begin
         board_ff <= csr_data;
      end
   end

   // request check: order the endpoints, test against board and colors
   always_comb begin
      eff_len   = (board_ff > POS_CAP) ? POS_CAP : board_ff;
      lo_end    = (req_data.left_end > req_data.right_end) ?
                  req_data.right_end : req_data.left_end;
      hi_end    = (req_data.left_end > req_data.right_end) ?
                  req_data.left_end : req_data.right_end;
      color_bad = (req_data.command == CMD_ASSIGN) &&
                  ((req_data.paint_color == '0) ||
                   ({1'b0, req_data.paint_color} > 7'(COLORS)));
      job.bad     = (lo_end == '0) || (hi_end > eff_len) || color_bad;
      job.command = req_data.command;
      job.first   = lo_end;
      job.last    = hi_end;
      job.color   = req_data.paint_color;
   end

   assign req_ready = walk_stat.idle;
   assign start     = req_valid && req_ready;

   rcac_walker #(
      .POSITIONS (POSITIONS),
      .AW        (AW),
      .CW        (CW)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .job         (job),
      .slot_free   (slot_free),
      .tally_count (tally_count),
      .tally_ctl   (tally_ctl),
      .ram_we      (ram_we),
      .ram_re      (ram_re),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .result      (result),
      .stat        (walk_stat)
   );

   // colors are stored as color - 1, so a cleared entry is color 1
   rcac_color_ram #(
      .DEPTH (POSITIONS),
      .AW    (AW),
      .DW    (CW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   rcac_tally #(
      .COLORS (COLORS),
      .CW     (CW)
   ) u_tally (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tally_ctl),
      .rd_data (ram_rdata),
      .count   (tally_count)
   );

   // rsp output register
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (walk_stat.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (walk_stat.done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result is only handed over when the rsp register can take it
   a_done_slot: assert property (@(posedge clock) disable iff (reset)
      walk_stat.done |-> slot_free)
      else $error("result loaded over an untaken one");

   // the store is never read and written in the same cycle
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("store read and write collide");

   // a rejected request leaves the store untouched
   a_bad_nowrite: assert property (@(posedge clock) disable iff (reset)
      (start && job.bad) |=> !ram_we)
      else $error("rejected request wrote the store");

   // no request is taken during the clearing pass
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      walk_stat.clearing |-> !req_ready)
      else $error("request accepted while clearing");

endmodule

// File: hdl/rcac_color_ram.sv
// Color store: one entry per board position, single port, registered read.
`timescale 1ns / 1ps
module rcac_color_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic          rd_en,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wr_data,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/rcac_tally.sv
// Distinct color tally: seen mask and counter fed by the store read data.
`timescale 1ns / 1ps
module rcac_tally
   import rcac_pkg::*;
#(
   parameter int COLORS = 32,
   parameter int CW     = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  tally_ctl_type      ctl,
   input  logic [CW-1:0]      rd_data,
   output logic [COUNT_W-1:0] count
);

   localparam int CNT_W = $clog2(COLORS + 1);

   logic [COLORS-1:0] seen_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              sample_ff;   // read data valid this cycle
   logic [6:0]        count_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= 1'b0;
         seen_ff   <= '0;
         count_ff  <= '0;
      end else begin
         sample_ff <= ctl.read;
         if (ctl.clear) begin
            seen_ff  <= '0;
            count_ff <= '0;
         end else if (sample_ff && !seen_ff[rd_data]) begin
            seen_ff[rd_data] <= 1'b1;
            count_ff         <= count_ff + CNT_W'(1);
         end
      end
   end

   // saturate at the field maximum
   assign count_wide = 7'(count_ff);
   assign count      = count_wide[6] ? 6'd63 : count_wide[5:0];

endmodule

// File: hdl/rcac_walker.sv
// Range walker: clearing pass, paint and scan sequencing, result hold.
`timescale 1ns / 1ps
module rcac_walker
   import rcac_pkg::*;
#(
   parameter int POSITIONS = 1024,
   parameter int AW        = 10,
   parameter int CW        = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  job_type            job,
   input  logic               slot_free,
   input  logic [COUNT_W-1:0] tally_count,
   output tally_ctl_type      tally_ctl,
   output logic               ram_we,
   output logic               ram_re,
   output logic [AW-1:0]      ram_addr,
   output logic [CW-1:0]      ram_wdata,
   output rsp_type            result,
   output walk_stat_type      stat
);

   localparam logic [AW-1:0] ADDR_MAX = AW'(POSITIONS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PAINT,
      ST_SCAN,
      ST_LAST,
      ST_FINISH
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] addr_ff;
   logic [AW-1:0] last_ff;
   logic [CW-1:0] color_ff;
   logic          bad_ff;
   logic          cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         addr_ff  <= '0;
         last_ff  <= '0;
         color_ff <= '0;
         bad_ff   <= 1'b0;
         cmd_ff   <= CMD_ASSIGN;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (addr_ff == ADDR_MAX) begin
                  state_ff <= ST_IDLE;
               end else begin
                  addr_ff <= addr_ff + AW'(1);
               end
            end
            ST_IDLE: begin
               if (start) begin
                  addr_ff  <= AW'(job.first - POS_W'(1));
                  last_ff  <= AW'(job.last - POS_W'(1));
                  color_ff <= CW'(job.color - COLOR_W'(1));
                  bad_ff   <= job.bad;
                  cmd_ff   <= job.command;
                  if (job.bad) begin
                     state_ff <= ST_FINISH;
                  end else if (job.command == CMD_ASSIGN) begin
                     state_ff <= ST_PAINT;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_PAINT: begin
               if (addr_ff == last_ff) begin
                  state_ff <= ST_FINISH;
               end else begin
                  addr_ff <= addr_ff + AW'(1);
               end
            end
            ST_SCAN: begin
               if (addr_ff == last_ff) begin
                  state_ff <= ST_LAST;
               end else begin
                  addr_ff <= addr_ff + AW'(1);
               end
            end
            ST_LAST: begin
               state_ff <= ST_FINISH;   // last read data lands in the tally
            end
            ST_FINISH: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      ram_we          = (state_ff == ST_CLEAR) || (state_ff == ST_PAINT);
      ram_re          = (state_ff == ST_SCAN);
      ram_addr        = addr_ff;
      ram_wdata       = (state_ff == ST_CLEAR) ? '0 : color_ff;
      tally_ctl.clear = (state_ff == ST_IDLE) && start;
      tally_ctl.read  = (state_ff == ST_SCAN);
      result.bad_range      = bad_ff;
      result.distinct_count = (!bad_ff && cmd_ff == CMD_COUNT) ? tally_count : '0;
      stat.idle       = (state_ff == ST_IDLE);
      stat.clearing   = (state_ff == ST_CLEAR);
      stat.done       = (state_ff == ST_FINISH) && slot_free;
   end

endmodule
